[design/fp16_remainder_mod_modulo_unit_macros.svh]
// assertion macros for the fp16 remainder unit
`ifndef FP16_REMAINDER_MOD_MODULO_UNIT_MACROS_SVH
`define FP16_REMAINDER_MOD_MODULO_UNIT_MACROS_SVH

// implication checked at every clock edge outside reset
`define FRM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define FRM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/frm_pkg.sv]
// ----------------------------------------------------------------------------
// frm_pkg
// shared types and constants of the fp16 remainder unit
// ----------------------------------------------------------------------------
package frm_pkg;

    localparam int unsigned HALF_W = 16;
    localparam int unsigned MANT_W = 11;
    localparam int unsigned EXP_W  = 5;
    // widest sum before packing: divisor significand shifted left up to 29
    localparam int unsigned WIDE_W = 42;
    localparam int unsigned CNT_W  = 6;

    localparam logic [HALF_W-1:0] DEF_NAN = 16'h7E00;
    localparam logic [HALF_W-1:0] QUIET   = 16'h0200;
    localparam logic [HALF_W-1:0] INF_PAT = 16'h7C00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REM,
        ST_SUM,
        ST_NORM,
        ST_PACK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;     // capture request and decode special cases
        logic step;     // one shift-subtract step
        logic sum;      // form divisor minus remainder where needed
        logic norm;     // one right shift toward 11 bits
        logic pack;     // round and pack
    } cmd_t;

    typedef struct packed {
        logic special;  // result settled at load
        logic steps_done;
        logic norm_done;
    } status_t;

endpackage

[design/fp16_remainder_mod_modulo_unit.sv]
// ----------------------------------------------------------------------------
// fp16_remainder_mod_modulo_unit
// binary16 truncated (mode 0) and floored (mode 1) remainder
// ----------------------------------------------------------------------------
// One request at a time. A special-case request (NaN, zero divisor, infinite
// operand) passes from accept through the remainder state to the done state,
// where its result is valid. Otherwise, when the dividend exponent is at least
// the divisor's, the shift-subtract loop runs one step per cycle for the 11
// significand bits plus the exponent difference (0 to 29), so up to 40 steps;
// when it is smaller there are no steps. Then the modulo sum is formed, right
// shifts bring the sum down to 11 bits (only a floored sum with the smaller
// dividend exponent can be wide, up to 29 shifts), the shifting ends and the
// sum is rounded and packed. The result waits in its register until taken;
// the next request is accepted the cycle after the result leaves.
module fp16_remainder_mod_modulo_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic        mode,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] remainder
);

    frm_pkg::cmd_t    cmd;
    frm_pkg::status_t status;

    // sequencer
    frm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (valid),
        .ready     (ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic
    frm_dp u_dp
    (
        .clk       (clk),
        .cmd       (cmd),
        .mode      (mode),
        .dividend  (dividend),
        .divisor   (divisor),
        .status    (status),
        .remainder (remainder)
    );

endmodule

[design/frm_ctrl.sv]
// ----------------------------------------------------------------------------
// frm_ctrl
// sequencer of the remainder unit
// ----------------------------------------------------------------------------
module frm_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid,
    output logic             ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  frm_pkg::status_t status,
    output frm_pkg::cmd_t    cmd
);

    frm_pkg::state_t state_reg;
    frm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= frm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            frm_pkg::ST_IDLE:
            begin
                if (valid)
                begin
                    state_next = frm_pkg::ST_REM;
                end
            end
            frm_pkg::ST_REM:
            begin
                if (status.special)
                begin
                    state_next = frm_pkg::ST_DONE;
                end
                else if (status.steps_done)
                begin
                    state_next = frm_pkg::ST_SUM;
                end
            end
            frm_pkg::ST_SUM:
            begin
                state_next = frm_pkg::ST_NORM;
            end
            frm_pkg::ST_NORM:
            begin
                if (status.norm_done)
                begin
                    state_next = frm_pkg::ST_PACK;
                end
            end
            frm_pkg::ST_PACK:
            begin
                state_next = frm_pkg::ST_DONE;
            end
            frm_pkg::ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = frm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = frm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        ready     = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            frm_pkg::ST_IDLE:
            begin
                ready    = 1'b1;
                cmd.load = valid;
            end
            frm_pkg::ST_REM:
            begin
                cmd.step = !status.special && !status.steps_done;
            end
            frm_pkg::ST_SUM:
            begin
                cmd.sum = 1'b1;
            end
            frm_pkg::ST_NORM:
            begin
                cmd.norm = !status.norm_done;
            end
            frm_pkg::ST_PACK:
            begin
                cmd.pack = 1'b1;
            end
            frm_pkg::ST_DONE:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `include "fp16_remainder_mod_modulo_unit_macros.svh"

    `FRM_ASSERT_IMP(a_load_idle, clk, rst_n, cmd.load, state_reg == frm_pkg::ST_IDLE, "load outside idle")
    `FRM_ASSERT_NXT(a_hold_done, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
    `FRM_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd), "more than one command")

endmodule

[design/frm_dp.sv]
// ----------------------------------------------------------------------------
// frm_dp
// datapath: special cases, shift-subtract remainder, modulo sum, round, pack
// ----------------------------------------------------------------------------
module frm_dp
(
    input  logic                         clk,
    input  frm_pkg::cmd_t                cmd,
    input  logic                         mode,
    input  logic [frm_pkg::HALF_W-1:0]   dividend,
    input  logic [frm_pkg::HALF_W-1:0]   divisor,
    output frm_pkg::status_t             status,
    output logic [frm_pkg::HALF_W-1:0]   remainder
);

    localparam int unsigned MW = frm_pkg::MANT_W;
    localparam int unsigned WW = frm_pkg::WIDE_W;
    localparam int unsigned CW = frm_pkg::CNT_W;

    logic              special_reg;
    logic [15:0]       res_reg;
    logic [MW:0]       rm_reg;       // partial remainder, one spare bit for the shift
    logic [MW-1:0]     qa_reg;       // dividend significand bits still to bring down
    logic [MW-1:0]     mb_reg;
    logic [4:0]        eb_reg;
    logic [4:0]        er_reg;
    logic [CW-1:0]     cnt_reg;      // steps left
    logic              sign_reg;
    logic              sa_reg;
    logic              flip_reg;
    logic [WW-1:0]     m_reg;
    logic [CW-1:0]     e_reg;
    logic              rnd_reg;
    logic              sticky_reg;

    // decode of the request
    logic        a_nan, b_nan, a_inf, b_inf, b_zero, sa, sb;
    logic [MW-1:0] ma, mb;
    logic [4:0]  ea, eb;

    always_comb
    begin
        sa     = dividend[15];
        sb     = divisor[15];
        a_nan  = (dividend[14:10] == 5'h1F) && (dividend[9:0] != 10'd0);
        b_nan  = (divisor[14:10] == 5'h1F) && (divisor[9:0] != 10'd0);
        a_inf  = dividend[14:0] == frm_pkg::INF_PAT[14:0];
        b_inf  = divisor[14:0] == frm_pkg::INF_PAT[14:0];
        b_zero = divisor[14:0] == 15'd0;
        ma     = (dividend[14:10] == 5'd0) ? {1'b0, dividend[9:0]} : {1'b1, dividend[9:0]};
        mb     = (divisor[14:10] == 5'd0) ? {1'b0, divisor[9:0]} : {1'b1, divisor[9:0]};
        ea     = (dividend[14:10] == 5'd0) ? 5'd1 : dividend[14:10];
        eb     = (divisor[14:10] == 5'd0) ? 5'd1 : divisor[14:10];
    end

    // one conditional subtract, bringing down the next dividend bit
    logic [MW:0] sub_in;
    logic [MW:0] sub_out;
    always_comb
    begin
        sub_in  = {rm_reg[MW-1:0], qa_reg[MW-1]};
        sub_out = (sub_in >= {1'b0, mb_reg}) ? sub_in - {1'b0, mb_reg} : sub_in;
    end

    // round and pack from m_reg (below 2048), e_reg
    logic [MW:0]  mr;
    logic [CW-1:0] er2;
    logic [15:0]  packed_v;
    logic [3:0]   lz;
    logic [CW-1:0] sh;
    logic [MW:0]  ms;
    always_comb
    begin
        mr  = m_reg[MW:0] + {{MW{1'b0}}, (rnd_reg && (sticky_reg || m_reg[0]))};
        er2 = e_reg;
        if (mr[MW])
        begin
            mr  = {1'b0, 1'b1, {(MW-1){1'b0}}};
            er2 = e_reg + 1'b1;
        end
        lz = 4'd0;
        for (int i = MW - 1; i >= 0; i--)
        begin
            if (mr[i] && lz == 4'd0)
            begin
                lz = 4'(MW - 1 - i) + 4'd1;
            end
        end
        // shift up by leading zeros, limited by exponent
        if (lz == 4'd0)
        begin
            sh = '0;
        end
        else if (CW'(lz - 4'd1) < er2)
        begin
            sh = CW'(lz - 4'd1);
        end
        else
        begin
            sh = er2 - 1'b1;
        end
        ms = mr << sh;
        if (mr == '0)
        begin
            packed_v = {sign_reg, 15'd0};
        end
        else if ((er2 - sh) > CW'(30))
        begin
            packed_v = {sign_reg, frm_pkg::INF_PAT[14:0]};
        end
        else if (ms[MW-1])
        begin
            packed_v = {sign_reg, 5'(er2 - sh), ms[9:0]};
        end
        else
        begin
            packed_v = {sign_reg, 5'd0, ms[9:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            special_reg <= 1'b1;
            sa_reg      <= sa;
            sign_reg    <= sa;
            mb_reg      <= mb;
            eb_reg      <= eb;
            flip_reg    <= mode && (sa != sb);
            cnt_reg     <= '0;
            rnd_reg     <= 1'b0;
            sticky_reg  <= 1'b0;
            if (a_nan)
            begin
                res_reg <= dividend | frm_pkg::QUIET;
            end
            else if (b_nan)
            begin
                res_reg <= divisor | frm_pkg::QUIET;
            end
            else if (b_zero || a_inf)
            begin
                res_reg <= frm_pkg::DEF_NAN;
            end
            else if (b_inf)
            begin
                res_reg <= dividend;
            end
            else
            begin
                special_reg <= 1'b0;
                if (ea < eb)
                begin
                    rm_reg <= {1'b0, ma};
                    er_reg <= ea;
                end
                else
                begin
                    // long division of the dividend significand, then the
                    // exponent difference in zero bits
                    rm_reg  <= '0;
                    qa_reg  <= ma;
                    er_reg  <= eb;
                    cnt_reg <= CW'(ea - eb) + CW'(MW);
                end
            end
        end
        else if (cmd.step)
        begin
            rm_reg  <= sub_out;
            qa_reg  <= {qa_reg[MW-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
        end
        else if (cmd.sum)
        begin
            if (rm_reg == '0)
            begin
                m_reg    <= '0;
                sign_reg <= sa_reg;
            end
            else if (flip_reg)
            begin
                m_reg    <= (WW'(mb_reg) << (eb_reg - er_reg)) - WW'(rm_reg);
                sign_reg <= !sa_reg;
            end
            else
            begin
                m_reg <= WW'(rm_reg);
            end
            e_reg <= CW'(er_reg);
        end
        else if (cmd.norm)
        begin
            sticky_reg <= sticky_reg | rnd_reg;
            rnd_reg    <= m_reg[0];
            m_reg      <= m_reg >> 1;
            e_reg      <= e_reg + 1'b1;
        end
        else if (cmd.pack)
        begin
            res_reg <= packed_v;
        end
    end

    assign status.special    = special_reg;
    assign status.steps_done = cnt_reg == '0;
    assign status.norm_done  = m_reg[WW-1:MW] == '0;
    assign remainder         = res_reg;

endmodule
